>>> rtl/decimal_reciprocal_accumulator_macros.svh
// Assertion macros for the decimal reciprocal accumulator checker.
// Depends on nothing; included by the checker file.
`ifndef DECIMAL_RECIPROCAL_ACCUMULATOR_MACROS_SVH
`define DECIMAL_RECIPROCAL_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dra_pkg.sv
// Package for the decimal reciprocal accumulator: field widths, operation
// and status codes, defaults and the divider control word. No dependencies.
package dra_pkg;

   // Default sizes.
   localparam int FRACTION_DIGITS_DEF = 100;
   localparam int DIVISOR_BITS_DEF    = 20;

   // Fixed field widths.
   localparam int OPERATION_W = 2;
   localparam int POSITION_W  = 7;
   localparam int VALUE_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int DIGIT_W     = 4;

   // Number base of the stored digits.
   localparam int RADIX = 10;

   // Operation codes.
   localparam logic [OPERATION_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OPERATION_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPERATION_W-1:0] OP_CLEAR = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_DIV  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

   // Control word from the sequencer to the long-division unit.
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

endpackage

>>> rtl/dra_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Depends on nothing; used for the quotient and fraction digit stores.
module dra_ram #(
   parameter int DEPTH = 100,
   parameter int WIDTH = 4,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dra_div_unit.sv
// Long-division digit generator: one decimal quotient digit of 1/n per step.
// Depends on dra_pkg for widths, the radix and the control word.
module dra_div_unit import dra_pkg::*; #(
   parameter int DIVISOR_BITS = DIVISOR_BITS_DEF
) (
   input  logic                    clock,
   input  div_ctrl_type            ctrl,
   input  logic [DIVISOR_BITS-1:0] divisor,
   output logic [DIGIT_W-1:0]      digit,
   output logic                    whole
);

   localparam int MW = DIVISOR_BITS + DIGIT_W;

   logic [MW-1:0]           mult_ff [1:RADIX-1];
   logic [MW-1:0]           mult_in [1:RADIX-1];
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] rem_in;
   logic                    whole_ff;
   logic [MW-1:0]           rem_x10;
   logic [MW-1:0]           sub_sel;

   // Multiples of the divisor, formed once when a division starts.
   always_comb begin
      for (int k = 1; k < RADIX; k++) begin
         mult_in[k] = MW'(divisor) * MW'(k);
      end
   end

   // One digit step: scale the remainder by ten and pick the largest
   // multiple that still fits.
   always_comb begin
      rem_x10 = (MW'(rem_ff) << 3) + (MW'(rem_ff) << 1);
      digit   = '0;
      sub_sel = '0;
      for (int k = 1; k < RADIX; k++) begin
         if (rem_x10 >= mult_ff[k]) begin
            digit   = DIGIT_W'(k);
            sub_sel = mult_ff[k];
         end
      end
      rem_in = DIVISOR_BITS'(rem_x10 - sub_sel);
   end

   // A divisor of one gives a whole unit and a zero remainder; any larger
   // divisor starts with a remainder of one.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mult_ff  <= mult_in;
         rem_ff   <= DIVISOR_BITS'(divisor != DIVISOR_BITS'(1));
         whole_ff <= (divisor == DIVISOR_BITS'(1));
      end else if (ctrl.step) begin
         rem_ff <= rem_in;
      end
   end

   assign whole = whole_ff;

endmodule

>>> rtl/decimal_reciprocal_accumulator.sv
// Add: one division pass writes the quotient RAM a digit per cycle, then one
// carry pass reads both digit RAMs a digit per cycle, then the integer part is
// updated. Read of a fractional digit: one RAM read. Clear, zero divisor and
// unused codes go straight to the response. One word in flight; the next is
// accepted once the result sits in the output register.
// Reset (synchronous) clears the sequencer, integer part and digit valid bits.
module decimal_reciprocal_accumulator import dra_pkg::*; #(
   parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
   parameter int DIVISOR_BITS    = DIVISOR_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OPERATION_W-1:0]  req_operation,
   input  logic [DIVISOR_BITS-1:0] req_divisor,
   input  logic [POSITION_W-1:0]   req_position,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [VALUE_W-1:0]      rsp_value,
   output logic [STATUS_W-1:0]     rsp_status
);

   localparam int AW = $clog2(FRACTION_DIGITS);
   localparam logic [AW-1:0] LAST_IDX = AW'(FRACTION_DIGITS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_ACC,
      S_INT,
      S_READ,
      S_RESP
   } state_type;

   state_type                  state_ff, state_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [AW-1:0]              wr_idx_ff, wr_idx_in;
   logic                       inflight_ff, inflight_in;
   logic                       issued_ff, issued_in;
   logic                       carry_ff, carry_in;
   logic [VALUE_W-1:0]         int_ff, int_in;
   logic [FRACTION_DIGITS-1:0] valid_ff, valid_in;
   logic                       rd_valid_ff, rd_valid_in;
   logic [VALUE_W-1:0]         res_value_ff, res_value_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]         rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;

   logic                req_fire;
   div_ctrl_type        div_ctrl;
   logic [DIGIT_W-1:0]  div_digit;
   logic                div_whole;
   logic                quot_wr_en;
   logic                quot_rd_en;
   logic [DIGIT_W-1:0]  quot_q;
   logic                frac_wr_en;
   logic [AW-1:0]       frac_wr_addr;
   logic [DIGIT_W-1:0]  frac_wr_data;
   logic                frac_rd_en;
   logic [AW-1:0]       frac_rd_addr;
   logic [DIGIT_W-1:0]  frac_q;
   logic [DIGIT_W-1:0]  frac_digit;
   logic [DIGIT_W:0]    acc_sum;
   logic [VALUE_W:0]    int_sum;

   // Long division of one by the divisor.
   dra_div_unit #(
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_div (
      .clock   (clock),
      .ctrl    (div_ctrl),
      .divisor (req_divisor),
      .digit   (div_digit),
      .whole   (div_whole)
   );

   // Quotient digits, most significant first.
   dra_ram #(
      .DEPTH (FRACTION_DIGITS),
      .WIDTH (DIGIT_W)
   ) u_quot_ram (
      .clock   (clock),
      .wr_en   (quot_wr_en),
      .wr_addr (idx_ff),
      .wr_data (div_digit),
      .rd_en   (quot_rd_en),
      .rd_addr (idx_ff),
      .rd_data (quot_q)
   );

   // Accumulated fractional digits.
   dra_ram #(
      .DEPTH (FRACTION_DIGITS),
      .WIDTH (DIGIT_W)
   ) u_frac_ram (
      .clock   (clock),
      .wr_en   (frac_wr_en),
      .wr_addr (frac_wr_addr),
      .wr_data (frac_wr_data),
      .rd_en   (frac_rd_en),
      .rd_addr (frac_rd_addr),
      .rd_data (frac_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // A digit never written since reset or clear reads as zero.
   assign frac_digit = rd_valid_ff ? frac_q : '0;
   assign acc_sum    = (DIGIT_W+1)'(frac_digit) + (DIGIT_W+1)'(quot_q)
                     + (DIGIT_W+1)'(carry_ff);
   assign int_sum    = (VALUE_W+1)'(int_ff) + (VALUE_W+1)'(div_whole)
                     + (VALUE_W+1)'(carry_ff);

   // Sequencer: next-state and datapath control.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      wr_idx_in     = wr_idx_ff;
      inflight_in   = inflight_ff;
      issued_in     = issued_ff;
      carry_in      = carry_ff;
      int_in        = int_ff;
      valid_in      = valid_ff;
      rd_valid_in   = rd_valid_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      div_ctrl      = '0;
      quot_wr_en    = 1'b0;
      quot_rd_en    = 1'b0;
      frac_wr_en    = 1'b0;
      frac_wr_addr  = wr_idx_ff;
      frac_wr_data  = '0;
      frac_rd_en    = 1'b0;
      frac_rd_addr  = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_value_in  = '0;
               res_status_in = ST_OK;
               state_in      = S_RESP;
               case (req_operation)
                  OP_ADD: begin
                     if (req_divisor == '0) begin
                        res_status_in = ST_ZERO_DIV;
                     end else begin
                        div_ctrl.load = 1'b1;
                        idx_in        = '0;
                        state_in      = S_DIV;
                     end
                  end
                  OP_READ: begin
                     if (req_position == '0) begin
                        res_value_in = int_ff;
                     end else if (int'(req_position) <= FRACTION_DIGITS) begin
                        frac_rd_en   = 1'b1;
                        frac_rd_addr = AW'(POSITION_W'(req_position - 1'b1));
                        state_in     = S_READ;
                     end
                  end
                  OP_CLEAR: begin
                     valid_in = '0;
                     int_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Division pass: one quotient digit per cycle into the RAM.
         S_DIV: begin
            div_ctrl.step = 1'b1;
            quot_wr_en    = 1'b1;
            if (idx_ff == LAST_IDX) begin
               inflight_in = 1'b0;
               issued_in   = 1'b0;
               carry_in    = 1'b0;
               state_in    = S_ACC;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // Carry pass: read digit i while digit i+1 is added and written.
         S_ACC: begin
            inflight_in = 1'b0;
            if (inflight_ff) begin
               frac_wr_en = 1'b1;
               carry_in   = (acc_sum >= (DIGIT_W+1)'(RADIX));
               if (acc_sum >= (DIGIT_W+1)'(RADIX)) begin
                  frac_wr_data = DIGIT_W'(acc_sum - (DIGIT_W+1)'(RADIX));
               end else begin
                  frac_wr_data = DIGIT_W'(acc_sum);
               end
               valid_in[wr_idx_ff] = 1'b1;
               if (wr_idx_ff == '0) begin
                  state_in = S_INT;
               end
            end
            if (!issued_ff) begin
               quot_rd_en  = 1'b1;
               frac_rd_en  = 1'b1;
               wr_idx_in   = idx_ff;
               inflight_in = 1'b1;
               if (idx_ff == '0) begin
                  issued_in = 1'b1;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end

         // Integer part takes the whole unit and the final carry.
         S_INT: begin
            if (int_sum[VALUE_W]) begin
               int_in        = '1;
               res_status_in = ST_SATURATED;
            end else begin
               int_in        = int_sum[VALUE_W-1:0];
               res_status_in = ST_OK;
            end
            state_in = S_RESP;
         end

         S_READ: begin
            res_value_in = VALUE_W'(frac_digit);
            state_in     = S_RESP;
         end

         // Hand the result to the output register once it is free.
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (frac_rd_en) begin
         rd_valid_in = valid_ff[frac_rd_addr];
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inflight_ff  <= 1'b0;
         issued_ff    <= 1'b0;
         int_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         wr_idx_ff     <= wr_idx_in;
         inflight_ff   <= inflight_in;
         issued_ff     <= issued_in;
         carry_ff      <= carry_in;
         int_ff        <= int_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
         res_value_ff  <= res_value_in;
         res_status_ff <= res_status_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> rtl/dra_checker.sv
// Port-level checker for the decimal reciprocal accumulator, bound to the top.
// Depends on dra_pkg and the assertion macros header.
`include "decimal_reciprocal_accumulator_macros.svh"

module dra_checker import dra_pkg::*; #(
   parameter int DIVISOR_BITS = DIVISOR_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [OPERATION_W-1:0]  req_operation,
   input logic [DIVISOR_BITS-1:0] req_divisor,
   input logic [POSITION_W-1:0]   req_position,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [VALUE_W-1:0]      rsp_value,
   input logic [STATUS_W-1:0]     rsp_status
);

   // Only the three defined status codes ever leave the block.
   `DRA_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == ST_OK || rsp_status == ST_ZERO_DIV || rsp_status == ST_SATURATED, "undefined status code")

   // A flagged word comes from an add, whose value field is zero.
   `DRA_ASSERT_NOW(a_flag_value, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value == '0, "flagged word with non-zero value")

   // One word at a time: the block is busy right after taking a word.
   `DRA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second word taken while busy")

   // A pending result word stays until it is taken.
   `DRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_status), "result word dropped or changed")

endmodule

bind decimal_reciprocal_accumulator dra_checker #(
   .DIVISOR_BITS (DIVISOR_BITS)
) u_dra_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_operation (req_operation),
   .req_divisor   (req_divisor),
   .req_position  (req_position),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value     (rsp_value),
   .rsp_status    (rsp_status)
);
